FILE: rtl/exp_golomb_decoder_assert.svh
// Assertion macros shared by the Exp-Golomb decoder RTL.
`ifndef EXP_GOLOMB_DECODER_ASSERT_SVH
`define EXP_GOLOMB_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define EGD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed in %m");

// Consequent must hold in the cycle after the antecedent.
`define EGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed in %m");

`else

`define EGD_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define EGD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/egd_pkg.sv
// Shared constants and beat types of the Exp-Golomb decoder.
`timescale 1ns / 1ps
`default_nettype none

package egd_pkg;

	localparam int BYTE_W  = 8;
	localparam int SLOT_N  = BYTE_W;
	localparam int SLOT_IW = $clog2(SLOT_N);
	localparam int CODE_W  = 33;

	typedef struct packed {
		logic [BYTE_W-1:0] stream_byte;
	} stream_beat_t;

	typedef struct packed {
		logic signed [CODE_W-1:0] code_value;
		logic                     prefix_error;
		logic                     last_of_byte;
	} result_beat_t;

endpackage

`default_nettype wire

FILE: rtl/egd_stream_if.sv
// Valid/ready channel carrying one beat of a given payload type.
`timescale 1ns / 1ps
`default_nettype none

interface egd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/exp_golomb_decoder.sv
// Exp-Golomb ue/se decoder top level.
//
// Takes one bitstream byte per beat, MSB first, and returns one beat per completed
// code, in stream order, with last_of_byte set on the final code of each byte.
// A byte is taken every cycle while each byte completes at most one code and result
// is not stalled; the n codes of a byte leave one per cycle, stalls aside, through
// the single output register while the next byte waits. The first result of a byte
// passes the input register, slot buffer and output register. A zero prefix longer
// than MAX_PREFIX_ZEROS gives a beat with prefix_error set and value zero; the code
// search restarts at the next bit. signed_mode selects unsigned (0) or signed (1)
// mapping; the user must write it only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module exp_golomb_decoder #(
	parameter int MAX_PREFIX_ZEROS = 31
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata,
	egd_stream_if.sink    stream,
	egd_stream_if.source  result
);
	import egd_pkg::*;

	localparam int MW = MAX_PREFIX_ZEROS + 1;

	logic                      batch_valid;
	logic                      buf_free;
	logic [SLOT_N-1:0]         slot_vld;
	logic [SLOT_N-1:0][MW-1:0] slot_m;

	// Decode each byte into per-bit result slots
	egd_decode #(
		.MAX_PREFIX_ZEROS(MAX_PREFIX_ZEROS),
		.MW(MW)
	) u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream),
		.buf_free(buf_free),
		.batch_valid(batch_valid),
		.slot_vld(slot_vld),
		.slot_m(slot_m)
	);

	// Send the slots out one beat at a time
	egd_drain #(
		.MW(MW)
	) u_drain (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.batch_valid(batch_valid),
		.slot_vld(slot_vld),
		.slot_m(slot_m),
		.buf_free(buf_free),
		.result(result)
	);

endmodule

`default_nettype wire

FILE: rtl/egd_decode.sv
// Input register, bitstream state and the eight-bit decode pass.
`timescale 1ns / 1ps
`default_nettype none
`include "exp_golomb_decoder_assert.svh"

module egd_decode #(
	parameter int MAX_PREFIX_ZEROS = 31,
	parameter int MW = MAX_PREFIX_ZEROS + 1
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	egd_stream_if.sink                              stream,
	input  wire logic                               buf_free,
	output logic                                    batch_valid,
	output logic [egd_pkg::SLOT_N-1:0]              slot_vld,
	output logic [egd_pkg::SLOT_N-1:0][MW-1:0]      slot_m
);
	import egd_pkg::*;

	localparam int ZW = $clog2(MAX_PREFIX_ZEROS + 1);

	logic              s1_vld_q;
	logic [BYTE_W-1:0] byte_s1;

	// Code state: in suffix, zero count or bits still to gather, marked code
	logic          coll_q;
	logic [ZW-1:0] cnt_q;
	logic [MW-1:0] acc_q;

	logic          coll_c;
	logic [ZW-1:0] cnt_c;
	logic [MW-1:0] acc_c;
	logic          advance;

	assign stream.ready = !s1_vld_q || buf_free;
	assign advance      = s1_vld_q && buf_free;
	assign batch_valid  = s1_vld_q;

	// Hold one input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (stream.ready) begin
			s1_vld_q <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.data.stream_byte;
		end
	end

	// Walk the byte MSB first; each completed code lands in its bit's slot.
	// A code is kept as 2^Z + suffix (leading one marks Z); zero flags an error.
	always_comb begin
		coll_c   = coll_q;
		cnt_c    = cnt_q;
		acc_c    = acc_q;
		slot_vld = '0;
		slot_m   = '0;
		for (int i = 0; i < SLOT_N; i++) begin
			if (!coll_c) begin
				if (!byte_s1[BYTE_W-1-i]) begin
					if (cnt_c == ZW'(MAX_PREFIX_ZEROS)) begin
						// overlong prefix: report and restart the search
						slot_vld[i] = 1'b1;
						slot_m[i]   = '0;
						cnt_c       = '0;
					end else begin
						cnt_c = cnt_c + ZW'(1);
					end
				end else if (cnt_c == '0) begin
					slot_vld[i] = 1'b1;
					slot_m[i]   = MW'(1);
				end else begin
					coll_c = 1'b1;
					acc_c  = MW'(1);
				end
			end else begin
				acc_c = {acc_c[MW-2:0], byte_s1[BYTE_W-1-i]};
				cnt_c = cnt_c - ZW'(1);
				if (cnt_c == '0) begin
					slot_vld[i] = 1'b1;
					slot_m[i]   = acc_c;
					coll_c      = 1'b0;
				end
			end
		end
	end

	// Advance the code state when the byte moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coll_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
		end else if (advance) begin
			coll_q <= coll_c;
			cnt_q  <= cnt_c;
			acc_q  <= acc_c;
		end
	end

	`EGD_ASSERT_NOW(a_suffix_has_bits_left, clk, arst_n, coll_q, cnt_q != '0)

endmodule

`default_nettype wire

FILE: rtl/egd_drain.sv
// Result slot buffer, value mapping and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "exp_golomb_decoder_assert.svh"

module egd_drain #(
	parameter int MW = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic                               cfg_wdata,
	input  wire logic                               batch_valid,
	input  wire logic [egd_pkg::SLOT_N-1:0]         slot_vld,
	input  wire logic [egd_pkg::SLOT_N-1:0][MW-1:0] slot_m,
	output logic                                    buf_free,
	egd_stream_if.source                            result
);
	import egd_pkg::*;

	logic                      signed_mode_q;
	logic [SLOT_N-1:0]         buf_vld_s2;
	logic [SLOT_N-1:0][MW-1:0] buf_m_s2;
	logic                      res_vld_s3;
	result_beat_t              res_data_s3;

	logic [SLOT_IW-1:0] first;
	logic [SLOT_N-1:0]  rest;
	logic               pop;
	logic               load;
	logic [MW-1:0]      m_sel;
	logic [CODE_W-1:0]  m_ext;
	logic [CODE_W-1:0]  half;
	logic [CODE_W-1:0]  value;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
		end else if (cfg_we) begin
			signed_mode_q <= cfg_wdata;
		end
	end

	// Pick the earliest pending slot
	always_comb begin
		first = '0;
		for (int i = SLOT_N - 1; i >= 0; i--) begin
			if (buf_vld_s2[i]) begin
				first = SLOT_IW'(i);
			end
		end
	end

	assign rest     = buf_vld_s2 & (buf_vld_s2 - SLOT_N'(1));
	assign pop      = (buf_vld_s2 != '0) && (!res_vld_s3 || result.ready);
	assign buf_free = (buf_vld_s2 == '0) || (pop && rest == '0);
	assign load     = batch_valid && buf_free;

	// Refill with a new byte's slots or drop the slot just sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_vld_s2 <= '0;
		end else if (load) begin
			buf_vld_s2 <= slot_vld;
		end else if (pop) begin
			buf_vld_s2 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_m_s2 <= slot_m;
		end
	end

	// Map 2^Z + suffix: ue is m - 1, se is +m/2 for even m and -(m/2) for odd m
	assign m_sel = buf_m_s2[first];
	assign m_ext = {{(CODE_W - MW){1'b0}}, m_sel};
	assign half  = m_ext >> 1;

	always_comb begin
		if (m_sel == '0) begin
			value = '0;
		end else if (!signed_mode_q) begin
			value = m_ext - CODE_W'(1);
		end else if (m_sel[0]) begin
			value = CODE_W'(0) - half;
		end else begin
			value = half;
		end
	end

	// Output register: load on pop, clear once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s3 <= 1'b0;
		end else if (pop) begin
			res_vld_s3 <= 1'b1;
		end else if (result.ready) begin
			res_vld_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_data_s3.code_value   <= value;
			res_data_s3.prefix_error <= (m_sel == '0);
			res_data_s3.last_of_byte <= (rest == '0);
		end
	end

	assign result.valid = res_vld_s3;
	assign result.data  = res_data_s3;

	`EGD_ASSERT_NOW(a_pop_needs_slot, clk, arst_n, pop, buf_vld_s2 != '0)
	`EGD_ASSERT_NEXT(a_pop_drops_one, clk, arst_n, pop && !load, buf_vld_s2 == $past(rest))
	`EGD_ASSERT_NOW(a_error_is_zero, clk, arst_n, res_vld_s3 && res_data_s3.prefix_error, res_data_s3.code_value == '0)

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the Exp-Golomb ue/se decoder.
`timescale 1ns / 1ps

module testbench;
	import egd_pkg::*;

	localparam int MAX_ZEROS  = 31;
	localparam int MAX_CYCLES = 300000;
	localparam int SETTLE     = 8;

	typedef enum {RX_OPEN, RX_RANDOM, RX_STALLS} rx_style_t;

	// Tracks the decoder's bit-level state and the codes it must return
	class code_checker;
		bit             signed_mode;
		bit             in_suffix;
		logic [5:0]     zeros;
		logic [4:0]     suffix_left;
		logic [30:0]    suffix_bits;
		result_beat_t   pending_codes[$];
		int             mismatches;

		function logic [32:0] map_code(logic [32:0] k);
			if (!signed_mode)
				return k;
			if (k[0])
				return (k + 33'd1) >> 1;
			return 33'd0 - (k >> 1);
		endfunction

		// Walk the byte MSB first and queue every code it completes
		function void take_byte(logic [7:0] b);
			result_beat_t byte_codes[$];
			result_beat_t beat;
			logic [32:0]  k;
			for (int i = 7; i >= 0; i--) begin
				beat = '0;
				if (!in_suffix) begin
					if (!b[i]) begin
						zeros = zeros + 6'd1;
						if (zeros > MAX_ZEROS) begin
							beat.prefix_error = 1'b1;
							byte_codes.push_back(beat);
							zeros = '0;
						end
					end else if (zeros == 0) begin
						beat.code_value = map_code(33'd0);
						byte_codes.push_back(beat);
					end else begin
						in_suffix   = 1'b1;
						suffix_left = zeros[4:0];
						suffix_bits = '0;
					end
				end else begin
					suffix_bits = {suffix_bits[29:0], b[i]};
					suffix_left = suffix_left - 5'd1;
					if (suffix_left == 0) begin
						k = ((33'd1 << zeros[4:0]) - 33'd1) + {2'b00, suffix_bits};
						beat.code_value = map_code(k);
						byte_codes.push_back(beat);
						in_suffix   = 1'b0;
						zeros       = '0;
						suffix_bits = '0;
					end
				end
			end
			if (byte_codes.size() > 0)
				byte_codes[byte_codes.size() - 1].last_of_byte = 1'b1;
			foreach (byte_codes[j])
				pending_codes.push_back(byte_codes[j]);
		endfunction

		// Compare one result beat with the oldest queued code
		function void check_code(result_beat_t got);
			result_beat_t want;
			if (pending_codes.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected result beat: value %0d err %0b last %0b",
						$realtime, got.code_value, got.prefix_error, got.last_of_byte);
				mismatches++;
				return;
			end
			want = pending_codes.pop_front();
			if (got.code_value !== want.code_value || got.prefix_error !== want.prefix_error ||
					got.last_of_byte !== want.last_of_byte) begin
				if (mismatches < 10)
					$display("%0t: mismatch: exp value %0d err %0b last %0b, got %0d %0b %0b",
						$realtime, want.code_value, want.prefix_error, want.last_of_byte,
						got.code_value, got.prefix_error, got.last_of_byte);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	egd_stream_if #(.payload_t(stream_beat_t)) stream_ch ();
	egd_stream_if #(.payload_t(result_beat_t)) result_ch ();

	exp_golomb_decoder #(
		.MAX_PREFIX_ZEROS(MAX_ZEROS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.stream(stream_ch),
		.result(result_ch)
	);

	code_checker chk = new();

	bit        stream_bits[$];
	int        bytes_sent;
	int        burst_left;
	bit        steady_sender;
	rx_style_t rx_style;
	int        rx_left;
	int        rx_stall;
	int        cycles;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// End the run if the decoder hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Sample accepted beats on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				chk.check_code(result_ch.data);
			if (stream_ch.valid && stream_ch.ready)
				chk.take_byte(stream_ch.data.stream_byte);
		end
	end

	// Drive result ready, switching between open, random and long-stall styles
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 2));
			rx_left  = $urandom_range(10, 80);
		end
		rx_left--;
		case (rx_style)
			RX_OPEN: begin
				result_ch.ready <= 1'b1;
			end
			RX_RANDOM: begin
				result_ch.ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				if (rx_stall > 0) begin
					rx_stall--;
					result_ch.ready <= 1'b0;
				end else begin
					result_ch.ready <= 1'b1;
					if ($urandom_range(0, 5) == 0)
						rx_stall = $urandom_range(1, 12);
				end
			end
		endcase
	end

	// Present one byte and hold it until the decoder takes it
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady_sender ? 0 : $urandom_range(0, 6);
			repeat (gap) begin
				@(negedge clk);
				stream_ch.valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		stream_ch.valid            <= 1'b1;
		stream_ch.data.stream_byte <= b;
		do
			@(posedge clk);
		while (!stream_ch.ready);
		bytes_sent++;
	endtask

	task automatic go_idle();
		@(negedge clk);
		stream_ch.valid <= 1'b0;
	endtask

	// Hold until every queued code has come back, then let the pipeline settle
	task automatic wait_drained();
		while (chk.pending_codes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(input bit mode);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		chk.signed_mode = mode;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Append one code: z zeros, a one, then z suffix bits
	task automatic push_code(input int z, input logic [30:0] suffix);
		repeat (z) stream_bits.push_back(1'b0);
		stream_bits.push_back(1'b1);
		for (int i = z - 1; i >= 0; i--)
			stream_bits.push_back(suffix[i]);
	endtask

	task automatic push_bits(input logic [31:0] value, input int n);
		for (int i = n - 1; i >= 0; i--)
			stream_bits.push_back(value[i]);
	endtask

	// Pack whole bytes off the bit queue and send them
	task automatic send_full_bytes();
		logic [7:0] b;
		while (stream_bits.size() >= 8) begin
			b = '0;
			repeat (8) b = {b[6:0], stream_bits.pop_front()};
			send_byte(b);
		end
	endtask

	// Pad with ones to a byte boundary and send the rest
	task automatic flush_bits();
		while (stream_bits.size() % 8 != 0)
			stream_bits.push_back(1'b1);
		send_full_bytes();
	endtask

	// Mostly well-formed codes, some noise, overlong prefixes and cut-off codes
	task automatic random_phase(input int n_bytes);
		int          goal;
		int          pick;
		int          z;
		logic [31:0] mask;
		goal = bytes_sent + n_bytes;
		while (bytes_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					z = $urandom_range(0, 3);
				else if (pick < 9)
					z = $urandom_range(4, 12);
				else
					z = $urandom_range(13, 31);
				mask = (32'd1 << z) - 32'd1;
				push_code(z, 31'($urandom() & mask));
			end else if (pick < 80) begin
				push_bits($urandom(), 8);
			end else if (pick < 87) begin
				repeat ($urandom_range(32, 40)) stream_bits.push_back(1'b0);
			end else if (pick < 94) begin
				z = $urandom_range(2, 31);
				repeat (z) stream_bits.push_back(1'b0);
				stream_bits.push_back(1'b1);
				push_bits($urandom(), $urandom_range(0, z - 1));
			end else begin
				repeat ($urandom_range(8, 16)) stream_bits.push_back(1'b1);
			end
			send_full_bytes();
		end
		flush_bits();
	endtask

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = 1'b0;
		stream_ch.valid     = 1'b0;
		stream_ch.data      = '0;
		result_ch.ready     = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Unsigned: eight codes in one byte, overlong prefix, largest code number
		write_mode(1'b0);
		send_byte(8'hFF);
		repeat (4) send_byte(8'h00);
		push_code(31, 31'h7FFF_FFFF);
		flush_bits();
		go_idle();
		wait_drained();

		// Signed: most negative, most positive, then +1 and -1
		write_mode(1'b1);
		push_code(31, 31'h7FFF_FFFF);
		push_code(31, 31'h7FFF_FFFE);
		push_code(1, 31'd0);
		push_code(1, 31'd1);
		flush_bits();
		go_idle();
		wait_drained();

		write_mode(1'b0);
		random_phase(95);
		go_idle();
		wait_drained();

		write_mode(1'b1);
		steady_sender = 1'b1;
		random_phase(95);
		steady_sender = 1'b0;
		random_phase(95);
		go_idle();
		wait_drained();

		write_mode(1'b0);
		random_phase(95);
		go_idle();
		wait_drained();

		if (chk.mismatches == 0 && chk.pending_codes.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
